// ===== design/stok_pkg.sv =====
// Shared types, token codes and byte classification for the source tokenizer.
// No dependencies; used by every design file.
package stok_pkg;

   localparam int OFFSET_BITS_DEF = 32;
   localparam int LENGTH_BITS_DEF = 16;
   localparam int LINE_BITS_DEF   = 24;

   localparam int KIND_BITS     = 5;
   localparam int ERR_BITS      = 2;
   localparam int PREFIX_DEPTH  = 7;
   localparam int PIDX_W        = $clog2(PREFIX_DEPTH);
   localparam int RESQ_DEPTH    = 4;   // power of two

   // token kinds
   localparam logic [KIND_BITS-1:0] K_EOF     = 5'd0;
   localparam logic [KIND_BITS-1:0] K_ILLEGAL = 5'd1;
   localparam logic [KIND_BITS-1:0] K_IDENT   = 5'd2;
   localparam logic [KIND_BITS-1:0] K_INT     = 5'd3;
   localparam logic [KIND_BITS-1:0] K_STRING  = 5'd4;
   localparam logic [KIND_BITS-1:0] K_LPAREN  = 5'd5;
   localparam logic [KIND_BITS-1:0] K_RPAREN  = 5'd6;
   localparam logic [KIND_BITS-1:0] K_LBRACE  = 5'd7;
   localparam logic [KIND_BITS-1:0] K_RBRACE  = 5'd8;
   localparam logic [KIND_BITS-1:0] K_SEMI    = 5'd9;
   localparam logic [KIND_BITS-1:0] K_COMMA   = 5'd10;
   localparam logic [KIND_BITS-1:0] K_MINUS   = 5'd11;
   localparam logic [KIND_BITS-1:0] K_PLUS    = 5'd12;
   localparam logic [KIND_BITS-1:0] K_SLASH   = 5'd13;
   localparam logic [KIND_BITS-1:0] K_STAR    = 5'd14;
   localparam logic [KIND_BITS-1:0] K_LT      = 5'd15;
   localparam logic [KIND_BITS-1:0] K_GT      = 5'd16;
   localparam logic [KIND_BITS-1:0] K_BANG    = 5'd17;
   localparam logic [KIND_BITS-1:0] K_NOT_EQ  = 5'd18;
   localparam logic [KIND_BITS-1:0] K_ASSIGN  = 5'd19;
   localparam logic [KIND_BITS-1:0] K_EQ      = 5'd20;
   localparam logic [KIND_BITS-1:0] K_FN      = 5'd21;
   localparam logic [KIND_BITS-1:0] K_LET     = 5'd22;
   localparam logic [KIND_BITS-1:0] K_TRUE    = 5'd23;
   localparam logic [KIND_BITS-1:0] K_FALSE   = 5'd24;
   localparam logic [KIND_BITS-1:0] K_IF      = 5'd25;
   localparam logic [KIND_BITS-1:0] K_ELSE    = 5'd26;
   localparam logic [KIND_BITS-1:0] K_RETURN  = 5'd27;

   // error codes
   localparam logic [ERR_BITS-1:0] ERR_NONE       = 2'd0;
   localparam logic [ERR_BITS-1:0] ERR_UNTERM     = 2'd1;
   localparam logic [ERR_BITS-1:0] ERR_UNEXPECTED = 2'd2;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUMBER,
      MODE_STRING,
      MODE_BANG,
      MODE_EQUAL,
      MODE_DONE
   } scan_mode_type;

   typedef logic [PREFIX_DEPTH-1:0][7:0] prefix_type;

   // results pushed into the queue this cycle; second implies first
   typedef struct packed {
      logic first;
      logic second;
   } push_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c == "_");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0" && c <= "9");
   endfunction

   // single-byte punctuation; K_EOF means "not punctuation"
   function automatic logic [KIND_BITS-1:0] single_kind(input logic [7:0] c);
      logic [KIND_BITS-1:0] k;
      case (c)
         "(":     k = K_LPAREN;
         ")":     k = K_RPAREN;
         "{":     k = K_LBRACE;
         "}":     k = K_RBRACE;
         ";":     k = K_SEMI;
         ",":     k = K_COMMA;
         "-":     k = K_MINUS;
         "+":     k = K_PLUS;
         "/":     k = K_SLASH;
         "*":     k = K_STAR;
         "<":     k = K_LT;
         ">":     k = K_GT;
         default: k = K_EOF;
      endcase
      return k;
   endfunction

   // exact keyword match on the stored identifier prefix
   function automatic logic [KIND_BITS-1:0] kw_kind(input prefix_type p,
                                                    input logic [PIDX_W-1:0] len);
      logic [KIND_BITS-1:0] k;
      k = K_IDENT;
      case (len)
         PIDX_W'(2): begin
            if (p[0] == "f" && p[1] == "n") k = K_FN;
            else if (p[0] == "i" && p[1] == "f") k = K_IF;
         end
         PIDX_W'(3): begin
            if (p[0] == "l" && p[1] == "e" && p[2] == "t") k = K_LET;
         end
         PIDX_W'(4): begin
            if (p[0] == "t" && p[1] == "r" && p[2] == "u" && p[3] == "e") k = K_TRUE;
            else if (p[0] == "e" && p[1] == "l" && p[2] == "s" && p[3] == "e") k = K_ELSE;
         end
         PIDX_W'(5): begin
            if (p[0] == "f" && p[1] == "a" && p[2] == "l" && p[3] == "s" && p[4] == "e")
               k = K_FALSE;
         end
         PIDX_W'(6): begin
            if (p[0] == "r" && p[1] == "e" && p[2] == "t" && p[3] == "u" && p[4] == "r" &&
                p[5] == "n")
               k = K_RETURN;
         end
         default: k = K_IDENT;
      endcase
      return k;
   endfunction

endpackage

// ===== design/stok_scan.sv =====
// Scanner state and per-byte token logic; emits up to two results per item.
// Depends on stok_pkg.
module stok_scan #(
   parameter int OFFSET_BITS = stok_pkg::OFFSET_BITS_DEF,
   parameter int LENGTH_BITS = stok_pkg::LENGTH_BITS_DEF,
   parameter int LINE_BITS   = stok_pkg::LINE_BITS_DEF,
   parameter int RES_W       = stok_pkg::KIND_BITS + stok_pkg::ERR_BITS + OFFSET_BITS +
                               LENGTH_BITS + LINE_BITS + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  logic [7:0]           ch,
   input  logic                 eoi,
   output stok_pkg::push_type   push,
   output logic [RES_W-1:0]     res0,
   output logic [RES_W-1:0]     res1
);

   stok_pkg::scan_mode_type mode_ff, mode_in;
   logic [OFFSET_BITS-1:0]  pos_ff, pos_in;
   logic [OFFSET_BITS-1:0]  tstart_ff, tstart_in;
   logic [LENGTH_BITS-1:0]  count_ff, count_in, count_sat;
   logic [LINE_BITS-1:0]    line_ff, line_in, line_sat;
   stok_pkg::prefix_type    prefix_ff;

   logic                    prefix_we;
   logic [stok_pkg::PIDX_W-1:0] prefix_idx, kw_len;

   // pending token flushed when the byte after it ends it, or by the end item
   logic                             pend;
   logic [stok_pkg::KIND_BITS-1:0]   pend_kind;
   logic [stok_pkg::ERR_BITS-1:0]    pend_err;
   logic [LENGTH_BITS-1:0]           pend_len;
   logic                             flush_v;

   logic                             main_v;
   logic [stok_pkg::KIND_BITS-1:0]   main_kind;
   logic [stok_pkg::ERR_BITS-1:0]    main_err;
   logic [OFFSET_BITS-1:0]           main_start;
   logic [LENGTH_BITS-1:0]           main_len;
   logic                             fall;
   logic                             more;
   logic [stok_pkg::KIND_BITS-1:0]   sk;

   assign count_sat = (count_ff == '1) ? count_ff : count_ff + LENGTH_BITS'(1);
   assign line_sat  = (line_ff == '1) ? line_ff : line_ff + LINE_BITS'(1);
   assign kw_len    = (count_ff < LENGTH_BITS'(stok_pkg::PREFIX_DEPTH)) ?
                      count_ff[stok_pkg::PIDX_W-1:0] : stok_pkg::PIDX_W'(stok_pkg::PREFIX_DEPTH);
   assign sk        = stok_pkg::single_kind(ch);

   always_comb begin
      pend      = 1'b0;
      pend_kind = stok_pkg::K_EOF;
      pend_err  = stok_pkg::ERR_NONE;
      pend_len  = count_ff;
      case (mode_ff)
         stok_pkg::MODE_IDENT: begin
            pend      = 1'b1;
            pend_kind = stok_pkg::kw_kind(prefix_ff, kw_len);
         end
         stok_pkg::MODE_NUMBER: begin
            pend      = 1'b1;
            pend_kind = stok_pkg::K_INT;
         end
         stok_pkg::MODE_BANG: begin
            pend      = 1'b1;
            pend_kind = stok_pkg::K_BANG;
            pend_len  = LENGTH_BITS'(1);
         end
         stok_pkg::MODE_EQUAL: begin
            pend      = 1'b1;
            pend_kind = stok_pkg::K_ASSIGN;
            pend_len  = LENGTH_BITS'(1);
         end
         stok_pkg::MODE_STRING: begin
            pend      = 1'b1;
            pend_kind = stok_pkg::K_ILLEGAL;
            pend_err  = stok_pkg::ERR_UNTERM;
         end
         default: pend = 1'b0;
      endcase
   end

   always_comb begin
      mode_in    = mode_ff;
      pos_in     = pos_ff;
      tstart_in  = tstart_ff;
      count_in   = count_ff;
      line_in    = line_ff;
      prefix_we  = 1'b0;
      prefix_idx = '0;
      flush_v    = 1'b0;
      main_v     = 1'b0;
      main_kind  = stok_pkg::K_EOF;
      main_err   = stok_pkg::ERR_NONE;
      main_start = pos_ff;
      main_len   = '0;
      fall       = 1'b0;
      more       = (mode_ff == stok_pkg::MODE_IDENT) ?
                   (stok_pkg::is_alpha(ch) || stok_pkg::is_digit(ch)) : stok_pkg::is_digit(ch);

      if (go) begin
         if (eoi) begin
            flush_v = pend;
            main_v  = 1'b1;
            mode_in = stok_pkg::MODE_DONE;
         end else if (mode_ff != stok_pkg::MODE_DONE) begin
            pos_in = pos_ff + OFFSET_BITS'(1);
            case (mode_ff)
               stok_pkg::MODE_IDENT, stok_pkg::MODE_NUMBER: begin
                  if (more) begin
                     if (count_ff < LENGTH_BITS'(stok_pkg::PREFIX_DEPTH)) begin
                        prefix_we  = 1'b1;
                        prefix_idx = count_ff[stok_pkg::PIDX_W-1:0];
                     end
                     count_in = count_sat;
                  end else begin
                     flush_v = 1'b1;
                     mode_in = stok_pkg::MODE_IDLE;
                     fall    = 1'b1;
                  end
               end
               stok_pkg::MODE_STRING: begin
                  count_in = count_sat;
                  if (ch == "\"") begin
                     main_v     = 1'b1;
                     main_kind  = stok_pkg::K_STRING;
                     main_start = tstart_ff;
                     main_len   = count_sat;
                     mode_in    = stok_pkg::MODE_IDLE;
                  end else if (ch == "\n") begin
                     line_in = line_sat;
                  end
               end
               stok_pkg::MODE_BANG, stok_pkg::MODE_EQUAL: begin
                  mode_in = stok_pkg::MODE_IDLE;
                  if (ch == "=") begin
                     main_v     = 1'b1;
                     main_kind  = (mode_ff == stok_pkg::MODE_BANG) ?
                                  stok_pkg::K_NOT_EQ : stok_pkg::K_EQ;
                     main_start = tstart_ff;
                     main_len   = LENGTH_BITS'(2);
                  end else begin
                     flush_v = 1'b1;
                     fall    = 1'b1;
                  end
               end
               stok_pkg::MODE_IDLE: fall = 1'b1;
               default: fall = 1'b0;
            endcase

            // byte starts afresh: whitespace, newline, a new token or a one-byte token
            if (fall) begin
               if (ch inside {" ", "\t", "\r"}) begin
                  mode_in = stok_pkg::MODE_IDLE;
               end else if (ch == "\n") begin
                  line_in = line_sat;
               end else if (stok_pkg::is_alpha(ch) || stok_pkg::is_digit(ch) ||
                            ch == "\"" || ch == "!" || ch == "=") begin
                  tstart_in = pos_ff;
                  count_in  = LENGTH_BITS'(1);
                  if (stok_pkg::is_alpha(ch)) begin
                     mode_in    = stok_pkg::MODE_IDENT;
                     prefix_we  = 1'b1;
                     prefix_idx = '0;
                  end else if (stok_pkg::is_digit(ch)) begin
                     mode_in = stok_pkg::MODE_NUMBER;
                  end else if (ch == "\"") begin
                     mode_in = stok_pkg::MODE_STRING;
                  end else if (ch == "!") begin
                     mode_in = stok_pkg::MODE_BANG;
                  end else begin
                     mode_in = stok_pkg::MODE_EQUAL;
                  end
               end else begin
                  main_v   = 1'b1;
                  main_len = LENGTH_BITS'(1);
                  if (sk != stok_pkg::K_EOF) begin
                     main_kind = sk;
                  end else begin
                     main_kind = stok_pkg::K_ILLEGAL;
                     main_err  = stok_pkg::ERR_UNEXPECTED;
                  end
               end
            end
         end
      end
   end

   // every result of one item reports the line as it stood before the item
   assign push.first  = flush_v | main_v;
   assign push.second = flush_v & main_v;
   assign res0 = flush_v ?
                 {pend_kind, pend_err, tstart_ff, pend_len, line_ff, ~main_v} :
                 {main_kind, main_err, main_start, main_len, line_ff, 1'b1};
   assign res1 = {main_kind, main_err, main_start, main_len, line_ff, 1'b1};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= stok_pkg::MODE_IDLE;
         pos_ff    <= '0;
         tstart_ff <= '0;
         count_ff  <= '0;
         line_ff   <= LINE_BITS'(1);
      end else begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         tstart_ff <= tstart_in;
         count_ff  <= count_in;
         line_ff   <= line_in;
      end
   end

   always_ff @(posedge clock) begin
      if (prefix_we) begin
         prefix_ff[prefix_idx] <= ch;
      end
   end

endmodule

// ===== design/stok_resq.sv =====
// Small result queue: up to two writes and one read per cycle.
// Depends on stok_pkg (push_type).
module stok_resq #(
   parameter int WIDTH = 8,
   parameter int DEPTH = stok_pkg::RESQ_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  stok_pkg::push_type push,
   input  logic [WIDTH-1:0]   din0,
   input  logic [WIDTH-1:0]   din1,
   output logic               room2,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [WIDTH-1:0]   dout
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] rd_ff, rd_in, wr_ff, wr_in, wr_next;
   logic [CNT_W-1:0] count_ff, count_in, n_push;
   logic             pop;

   assign pop       = out_valid & out_ready;
   assign out_valid = (count_ff != '0);
   assign dout      = mem_ff[rd_ff];
   assign room2     = (count_ff <= CNT_W'(DEPTH - 2));
   assign n_push    = CNT_W'(push.first) + CNT_W'(push.second);
   assign wr_next   = wr_ff + PTR_W'(1);
   assign wr_in     = wr_ff + PTR_W'(n_push);
   assign rd_in     = rd_ff + PTR_W'(pop);
   assign count_in  = count_ff + n_push - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff    <= '0;
         wr_ff    <= '0;
         count_ff <= '0;
      end else begin
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         mem_ff[wr_ff] <= din0;
      end
      if (push.second) begin
         mem_ff[wr_next] <= din1;
      end
   end

endmodule

// ===== design/source_tokenizer.sv =====
// Top level of the streaming source tokenizer: input register, scanner, result queue.
// Depends on stok_pkg, stok_scan and stok_resq.
//
// Usage:
//   req channel: one source byte per item (req_ch), or an end item with
//   req_end_of_input set. rsp channel: tokens with kind, error code, start
//   offset, length, line and a last flag marking the final token of an item.
//   An item yields zero, one or two tokens; a token that is closed by the
//   byte after it goes out ahead of the token that byte itself produces.
//   Path: an accepted item waits in the input register, then the scanner
//   writes its tokens into the queue that drives rsp.
//   Throughput: one item per cycle while the queue has room for two tokens;
//   the output side drains one token per cycle, so items that yield two
//   tokens are absorbed by the four-entry queue.
//   Reset (synchronous, active high): scanner idle, offset 0, line 1, queue
//   empty. After an end item the scanner stays finished: further bytes are
//   dropped and further end items give EOF again.
//   Stall: when rsp_ready is low the queue fills; req_ready falls once it
//   cannot take two more tokens, and rises again as the receiver drains it.
module source_tokenizer #(
   parameter int OFFSET_BITS = stok_pkg::OFFSET_BITS_DEF,
   parameter int LENGTH_BITS = stok_pkg::LENGTH_BITS_DEF,
   parameter int LINE_BITS   = stok_pkg::LINE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_ch,
   input  logic                           req_end_of_input,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [stok_pkg::KIND_BITS-1:0] rsp_kind,
   output logic [stok_pkg::ERR_BITS-1:0]  rsp_error_kind,
   output logic [OFFSET_BITS-1:0]         rsp_start_offset,
   output logic [LENGTH_BITS-1:0]         rsp_token_length,
   output logic [LINE_BITS-1:0]           rsp_line_number,
   output logic                           rsp_last
);

   localparam int RES_W = stok_pkg::KIND_BITS + stok_pkg::ERR_BITS + OFFSET_BITS +
                          LENGTH_BITS + LINE_BITS + 1;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_ch_ff;
   logic       in_eoi_ff;
   logic       accept;
   logic       go;         // item in the input register is scanned this cycle
   logic       room2;      // queue can take two more tokens

   stok_pkg::push_type push;
   logic [RES_W-1:0]   res0, res1, dout;

   assign go          = in_valid_ff & room2;
   assign req_ready   = ~in_valid_ff | go;
   assign accept      = req_valid & req_ready;
   assign in_valid_in = accept | (in_valid_ff & ~go);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ch_ff  <= req_ch;
         in_eoi_ff <= req_end_of_input;
      end
   end

   stok_scan #(
      .OFFSET_BITS (OFFSET_BITS),
      .LENGTH_BITS (LENGTH_BITS),
      .LINE_BITS   (LINE_BITS),
      .RES_W       (RES_W)
   ) u_scan (
      .clock (clock),
      .reset (reset),
      .go    (go),
      .ch    (in_ch_ff),
      .eoi   (in_eoi_ff),
      .push  (push),
      .res0  (res0),
      .res1  (res1)
   );

   stok_resq #(
      .WIDTH (RES_W),
      .DEPTH (stok_pkg::RESQ_DEPTH)
   ) u_resq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .din0      (res0),
      .din1      (res1),
      .room2     (room2),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .dout      (dout)
   );

   assign {rsp_kind, rsp_error_kind, rsp_start_offset, rsp_token_length,
           rsp_line_number, rsp_last} = dout;

endmodule

// ===== design/stok_checker.sv =====
// Port-level checks for source_tokenizer, attached with bind.
// Depends on stok_pkg.
module stok_checker #(
   parameter int OFFSET_BITS = stok_pkg::OFFSET_BITS_DEF,
   parameter int LENGTH_BITS = stok_pkg::LENGTH_BITS_DEF,
   parameter int LINE_BITS   = stok_pkg::LINE_BITS_DEF
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic [7:0]                     req_ch,
   input logic                           req_end_of_input,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [stok_pkg::KIND_BITS-1:0] rsp_kind,
   input logic [stok_pkg::ERR_BITS-1:0]  rsp_error_kind,
   input logic [OFFSET_BITS-1:0]         rsp_start_offset,
   input logic [LENGTH_BITS-1:0]         rsp_token_length,
   input logic [LINE_BITS-1:0]           rsp_line_number,
   input logic                           rsp_last
);

   // leaving reset: nothing to deliver, ready to take an item
   a_reset_clean: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("outputs not clean after reset");

   // a stalled token holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_kind) && $stable(rsp_error_kind) &&
          $stable(rsp_start_offset) && $stable(rsp_token_length) &&
          $stable(rsp_line_number) && $stable(rsp_last)))
      else $error("stalled token changed");

   // EOF closes its item, is empty and error free
   a_eof_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == stok_pkg::K_EOF) |->
         (rsp_last && rsp_token_length == '0 && rsp_error_kind == stok_pkg::ERR_NONE))
      else $error("malformed EOF token");

   // errors only travel on illegal tokens
   a_err_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_kind != stok_pkg::ERR_NONE) |->
         (rsp_kind == stok_pkg::K_ILLEGAL))
      else $error("error code on a legal token");

   // an unexpected character is always one byte long
   a_unexp_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_kind == stok_pkg::ERR_UNEXPECTED) |->
         (rsp_token_length == LENGTH_BITS'(1)))
      else $error("unexpected character with bad length");

endmodule

bind source_tokenizer stok_checker #(
   .OFFSET_BITS (OFFSET_BITS),
   .LENGTH_BITS (LENGTH_BITS),
   .LINE_BITS   (LINE_BITS)
) u_stok_checker (.*);
